// ===== design/itf_pkg.sv =====
// shared types and constants for the integer text formatter
// no dependencies
`timescale 1ns / 1ps

package itf_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } itf_char_t;

  localparam logic       ACT_LITERAL = 1'b0;
  localparam logic       ACT_NUMBER  = 1'b1;

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [7:0] HEX_LOWER_OFS = 8'h27;
  localparam logic [7:0] HEX_UPPER_OFS = 8'h07;

  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
  localparam int          RECIP10_SHIFT = 35;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    c = CHAR_ZERO + {4'd0, d};
    if (d > 4'd9) begin
      c = c + (upper ? HEX_UPPER_OFS : HEX_LOWER_OFS);
    end
    return c;
  endfunction

endpackage

// ===== design/itf_front.sv =====
// front end: accepts items, converts numbers to digits, sequences padding and characters
// depends on itf_pkg; feeds itf_queue
`timescale 1ns / 1ps

module itf_front import itf_pkg::*; #(
  parameter int MAX_DIGITS = 16,
  parameter int MAX_WIDTH  = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_char_in,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_radix_code,
  input  logic        in_is_signed,
  input  logic        in_zero_pad,
  input  logic        in_left_justify,
  input  logic        in_upper_hex,
  input  logic [5:0]  in_min_width,
  input  logic        crlf_enable,
  output logic        push_valid,
  output itf_char_t   push_data,
  input  logic        queue_full
);

  localparam int DIG_DEPTH = MAX_DIGITS + 1;
  localparam int IDX_W     = $clog2(DIG_DEPTH);
  localparam int CNT_W     = $clog2(MAX_DIGITS + 2);
  localparam int W_W       = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W     = ((W_W > CNT_W) ? W_W : CNT_W) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CR   = 4'd1;
  localparam logic [3:0] S_LIT  = 4'd2;
  localparam logic [3:0] S_CONV = 4'd3;
  localparam logic [3:0] S_SGN  = 4'd4;
  localparam logic [3:0] S_PREP = 4'd5;
  localparam logic [3:0] S_PADL = 4'd6;
  localparam logic [3:0] S_DIGS = 4'd7;
  localparam logic [3:0] S_PADR = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic [1:0]       radix_r, radix_nxt;
  logic             neg_r, neg_nxt;
  logic             zpad_r, zpad_nxt;
  logic             left_r, left_nxt;
  logic             upper_r, upper_nxt;
  logic [W_W-1:0]   w_r, w_nxt;
  logic [W_W-1:0]   pad_r, pad_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       digs_r [DIG_DEPTH];

  logic             dig_we;
  logic [7:0]       dig_wd;
  logic [63:0]      prod;
  logic [31:0]      quo;
  logic [3:0]       dig;
  logic             neg_in;
  logic [CMP_W-1:0] w_ext, len_ext;

  assign busy   = (state_r != S_IDLE);
  assign prod   = {32'd0, mag_r} * {32'd0, RECIP10};
  assign neg_in = (in_radix_code == RADIX_DEC) && in_is_signed && in_value[31];
  assign w_ext  = CMP_W'(w_r);
  assign len_ext = CMP_W'(cnt_r);

  // one digit per cycle, least significant first
  always_comb begin
    case (radix_r)
      RADIX_BIN: begin
        quo = {1'b0, mag_r[31:1]};
        dig = {3'd0, mag_r[0]};
      end
      RADIX_OCT: begin
        quo = {3'd0, mag_r[31:3]};
        dig = {1'b0, mag_r[2:0]};
      end
      RADIX_DEC: begin
        quo = {3'd0, prod[63:RECIP10_SHIFT]};
        dig = mag_r[3:0] - ({quo[0], 3'b000} + {quo[2:0], 1'b0});
      end
      default: begin
        quo = {4'd0, mag_r[31:4]};
        dig = mag_r[3:0];
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    char_nxt   = char_r;
    mag_nxt    = mag_r;
    radix_nxt  = radix_r;
    neg_nxt    = neg_r;
    zpad_nxt   = zpad_r;
    left_nxt   = left_r;
    upper_nxt  = upper_r;
    w_nxt      = w_r;
    pad_nxt    = pad_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    dig_we     = 1'b0;
    dig_wd     = digit_char(dig, upper_r);
    push_valid = 1'b0;
    push_data  = '{ch: char_r, last: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          char_nxt  = in_char_in;
          radix_nxt = in_radix_code;
          neg_nxt   = neg_in;
          mag_nxt   = neg_in ? (~in_value + 32'd1) : in_value;
          zpad_nxt  = in_zero_pad;
          left_nxt  = in_left_justify;
          upper_nxt = in_upper_hex;
          w_nxt     = ({1'b0, in_min_width} > 7'(MAX_WIDTH)) ? W_W'(MAX_WIDTH)
                                                             : W_W'(in_min_width);
          cnt_nxt   = '0;
          if (in_action == ACT_NUMBER) begin
            state_nxt = S_CONV;
          end else if (crlf_enable && in_char_in == CHAR_LF) begin
            state_nxt = S_CR;
          end else begin
            state_nxt = S_LIT;
          end
        end
      end
      S_CR: begin
        push_valid = 1'b1;
        push_data  = '{ch: CHAR_CR, last: 1'b0};
        if (!queue_full) begin
          state_nxt = S_LIT;
        end
      end
      S_LIT: begin
        push_valid = 1'b1;
        push_data  = '{ch: char_r, last: 1'b1};
        if (!queue_full) begin
          state_nxt = S_IDLE;
        end
      end
      S_CONV: begin
        dig_we  = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        mag_nxt = quo;
        if (quo == 32'd0 || cnt_r == CNT_W'(MAX_DIGITS - 1)) begin
          state_nxt = neg_r ? S_SGN : S_PREP;
        end
      end
      S_SGN: begin
        dig_we    = 1'b1;
        dig_wd    = CHAR_MINUS;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_PREP;
      end
      S_PREP: begin
        pad_nxt   = (w_ext > len_ext) ? W_W'(w_ext - len_ext) : '0;
        idx_nxt   = IDX_W'(cnt_r - CNT_W'(1));
        state_nxt = (!left_r && w_ext > len_ext) ? S_PADL : S_DIGS;
      end
      S_PADL: begin
        push_valid = 1'b1;
        push_data  = '{ch: (zpad_r ? CHAR_ZERO : CHAR_SPACE), last: 1'b0};
        if (!queue_full) begin
          pad_nxt = pad_r - W_W'(1);
          if (pad_r == W_W'(1)) begin
            state_nxt = S_DIGS;
          end
        end
      end
      S_DIGS: begin
        push_valid = 1'b1;
        push_data  = '{ch: digs_r[idx_r],
                       last: (idx_r == '0) && (!left_r || pad_r == '0)};
        if (!queue_full) begin
          if (idx_r == '0) begin
            state_nxt = (left_r && pad_r != '0) ? S_PADR : S_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      S_PADR: begin
        push_valid = 1'b1;
        push_data  = '{ch: CHAR_SPACE, last: (pad_r == W_W'(1))};
        if (!queue_full) begin
          pad_nxt = pad_r - W_W'(1);
          if (pad_r == W_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r  <= char_nxt;
    mag_r   <= mag_nxt;
    radix_r <= radix_nxt;
    neg_r   <= neg_nxt;
    zpad_r  <= zpad_nxt;
    left_r  <= left_nxt;
    upper_r <= upper_nxt;
    w_r     <= w_nxt;
    pad_r   <= pad_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
  end

  // digit buffer
  always_ff @(posedge clk) begin
    if (dig_we) begin
      digs_r[cnt_r[IDX_W-1:0]] <= dig_wd;
    end
  end

endmodule

// ===== design/itf_queue.sv =====
// short character queue between front end and output stage
// depends on itf_pkg
`timescale 1ns / 1ps

module itf_queue import itf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  itf_char_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output itf_char_t head
);

  itf_char_t           mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QUEUE_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/itf_back.sv =====
// output stage: drains the queue one character a cycle into the result registers
// depends on itf_pkg
`timescale 1ns / 1ps

module itf_back import itf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      queue_empty,
  input  itf_char_t head,
  output logic      pop,
  output logic      out_valid,
  output logic [7:0] out_char,
  output logic      out_last
);

  logic       valid_r, valid_nxt;
  logic       last_r, last_nxt;
  logic [7:0] char_r;

  assign pop       = !queue_empty;
  assign valid_nxt = !queue_empty;
  assign last_nxt  = !queue_empty && head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= head.ch;
  end

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule

// ===== design/integer_text_formatter.sv =====
// top level of the integer text formatter: crlf register, front end, queue, output stage
// depends on itf_pkg, itf_front, itf_queue, itf_back
//
//   channel   ports                          handshake
//   request   start, busy, in_*              taken when start=1 and busy=0
//   result    out_valid, out_char, out_last  one cycle per character, no backpressure
//   config    cfg_valid, cfg_ready, cfg_*    written when cfg_valid=1 and cfg_ready=1
//
// literal request: 1 or 2 characters
// number request: converts the digits (up to MAX_DIGITS), adds the sign if negative, sets up
//   the padding, then queues the characters (up to 63)
// a queued character passes through the queue memory and the output register before it leaves
// reset is synchronous; crlf_enable returns to 1
// the receiver cannot stall; the queue never fills
`timescale 1ns / 1ps

module integer_text_formatter import itf_pkg::*; #(
  parameter int MAX_DIGITS = 16,
  parameter int MAX_WIDTH  = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_char_in,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_radix_code,
  input  logic        in_is_signed,
  input  logic        in_zero_pad,
  input  logic        in_left_justify,
  input  logic        in_upper_hex,
  input  logic [5:0]  in_min_width,
  output logic        out_valid,
  output logic [7:0]  out_char,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_crlf_enable
);

  logic      crlf_r, crlf_nxt;
  logic      push_valid, queue_full, queue_empty, pop;
  itf_char_t push_data, head;

  assign cfg_ready = 1'b1;
  assign crlf_nxt  = (cfg_valid && cfg_ready) ? cfg_crlf_enable : crlf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crlf_r <= 1'b1;
    end else begin
      crlf_r <= crlf_nxt;
    end
  end

  itf_front #(
    .MAX_DIGITS(MAX_DIGITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_char_in     (in_char_in),
    .in_value       (in_value),
    .in_radix_code  (in_radix_code),
    .in_is_signed   (in_is_signed),
    .in_zero_pad    (in_zero_pad),
    .in_left_justify(in_left_justify),
    .in_upper_hex   (in_upper_hex),
    .in_min_width   (in_min_width),
    .crlf_enable    (crlf_r),
    .push_valid     (push_valid),
    .push_data      (push_data),
    .queue_full     (queue_full)
  );

  itf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_data(push_data),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  itf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .queue_empty(queue_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_char   (out_char),
    .out_last   (out_last)
  );

endmodule

// ===== design/itf_checker.sv =====
// port-level checks for the integer text formatter, bound to the top level
// depends on itf_pkg and integer_text_formatter
`timescale 1ns / 1ps

module itf_checker import itf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [7:0]  out_char,
  input logic        out_last
);

  // an accepted request always raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // inserted carriage return is immediately followed by its line feed
  a_crlf_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && out_char == CHAR_CR |=> out_valid && out_char == CHAR_LF)
    else $error("carriage return not followed by line feed");

  // a sign inside a field is always followed by a digit
  a_sign_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && out_char == CHAR_MINUS
    |=> out_valid && out_char >= CHAR_ZERO && out_char <= CHAR_NINE)
    else $error("minus sign not followed by a digit");

endmodule

bind integer_text_formatter itf_checker u_itf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_char (out_char),
  .out_last (out_last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench for integer_text_formatter: literal and number requests, crlf register writes
// every emitted character is checked against a behavioral formatter kept in this file
// depends on itf_pkg and the integer_text_formatter design

module testbench;
  import itf_pkg::*;

  localparam int DIGIT_LIMIT = 16;
  localparam int WIDTH_LIMIT = 63;

  typedef struct {
    logic        action;
    logic [7:0]  ch;
    logic [31:0] value;
    logic [1:0]  radix;
    logic        sgn;
    logic        zpad;
    logic        left;
    logic        upper;
    logic [5:0]  width;
  } fmt_request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = 1'b0;
  logic [7:0]  in_char_in = 8'd0;
  logic [31:0] in_value = 32'd0;
  logic [1:0]  in_radix_code = 2'd0;
  logic        in_is_signed = 1'b0;
  logic        in_zero_pad = 1'b0;
  logic        in_left_justify = 1'b0;
  logic        in_upper_hex = 1'b0;
  logic [5:0]  in_min_width = 6'd0;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_crlf_enable = 1'b0;

  itf_char_t pending_chars[$];
  itf_char_t head_char;
  logic      crlf_on = 1'b1;
  int        mismatch_count = 0;
  bit        quiet = 1'b0;

  integer_text_formatter uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_char_in      (in_char_in),
    .in_value        (in_value),
    .in_radix_code   (in_radix_code),
    .in_is_signed    (in_is_signed),
    .in_zero_pad     (in_zero_pad),
    .in_left_justify (in_left_justify),
    .in_upper_hex    (in_upper_hex),
    .in_min_width    (in_min_width),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_crlf_enable (cfg_crlf_enable)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // expected character run for one accepted request
  function automatic void format_field(input fmt_request_t r);
    logic [7:0]  run[$];
    logic [7:0]  digs[$];
    logic [31:0] v;
    logic [31:0] base;
    logic [31:0] d;
    logic [7:0]  pad;
    itf_char_t   c;
    int          w;
    bit          neg;
    if (r.action == ACT_LITERAL) begin
      if (crlf_on && r.ch == CHAR_LF) begin
        run.push_back(CHAR_CR);
      end
      run.push_back(r.ch);
    end else begin
      case (r.radix)
        RADIX_BIN: base = 32'd2;
        RADIX_OCT: base = 32'd8;
        RADIX_DEC: base = 32'd10;
        default:   base = 32'd16;
      endcase
      w = (int'(r.width) > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(r.width);
      v = r.value;
      neg = 1'b0;
      if (r.radix == RADIX_DEC && r.sgn && v[31]) begin
        v = 32'd0 - v;
        neg = 1'b1;
      end
      do begin
        d = v % base;
        v = v / base;
        if (d > 32'd9) begin
          digs.push_front(CHAR_ZERO + d[7:0] + (r.upper ? HEX_UPPER_OFS : HEX_LOWER_OFS));
        end else begin
          digs.push_front(CHAR_ZERO + d[7:0]);
        end
      end while (v != 32'd0 && digs.size() < DIGIT_LIMIT);
      if (neg) begin
        digs.push_front(CHAR_MINUS);
      end
      pad = r.zpad ? CHAR_ZERO : CHAR_SPACE;
      if (!r.left) begin
        for (int k = digs.size(); k < w; k++) run.push_back(pad);
      end
      foreach (digs[i]) run.push_back(digs[i]);
      if (r.left) begin
        for (int k = digs.size(); k < w; k++) run.push_back(CHAR_SPACE);
      end
    end
    foreach (run[i]) begin
      c.ch = run[i];
      c.last = (i == run.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic fmt_request_t literal_req(input logic [7:0] c);
    fmt_request_t r;
    r.action = ACT_LITERAL;
    r.ch = c;
    r.value = $urandom;
    r.radix = 2'($urandom_range(0, 3));
    r.sgn = 1'($urandom_range(0, 1));
    r.zpad = 1'($urandom_range(0, 1));
    r.left = 1'($urandom_range(0, 1));
    r.upper = 1'($urandom_range(0, 1));
    r.width = 6'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic fmt_request_t number_req(input logic [31:0] value, input logic [1:0] radix,
                                              input logic sgn, input logic zpad,
                                              input logic left, input logic upper,
                                              input logic [5:0] width);
    fmt_request_t r;
    r.action = ACT_NUMBER;
    r.ch = 8'($urandom_range(0, 255));
    r.value = value;
    r.radix = radix;
    r.sgn = sgn;
    r.zpad = zpad;
    r.left = left;
    r.upper = upper;
    r.width = width;
    return r;
  endfunction

  task automatic send_request(input fmt_request_t r);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 7) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_action <= r.action;
    in_char_in <= r.ch;
    in_value <= r.value;
    in_radix_code <= r.radix;
    in_is_signed <= r.sgn;
    in_zero_pad <= r.zpad;
    in_left_justify <= r.left;
    in_upper_hex <= r.upper;
    in_min_width <= r.width;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    format_field(r);
  endtask

  task automatic drain_output();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (pending_chars.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_chars.size() != 0) begin
      report($sformatf("%0d expected characters never arrived", pending_chars.size()));
      pending_chars.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_crlf(input logic en);
    while ($urandom_range(0, 99) < 7) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_crlf_enable <= en;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    crlf_on = en;
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected character %h last %b", out_char, out_last));
      end else begin
        head_char = pending_chars.pop_front();
        if (out_char !== head_char.ch || out_last !== head_char.last) begin
          report($sformatf("expected %h last %b, got %h last %b",
                           head_char.ch, head_char.last, out_char, out_last));
        end
      end
    end
  end

  task automatic test_literals();
    send_request(literal_req(8'h00));
    send_request(literal_req(8'hFF));
    send_request(literal_req(CHAR_LF));
    send_request(literal_req(CHAR_CR));
    send_request(literal_req(8'h61));
    drain_output();
  endtask

  task automatic test_crlf_off();
    write_crlf(1'b0);
    send_request(literal_req(CHAR_LF));
    send_request(literal_req(8'h41));
    drain_output();
    write_crlf(1'b1);
  endtask

  task automatic test_number_formats();
    send_request(number_req(32'd0, RADIX_BIN, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0));
    send_request(number_req(32'hFFFFFFFF, RADIX_BIN, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0));
    send_request(number_req(32'hFFFFFFFF, RADIX_OCT, 1'b0, 1'b0, 1'b0, 1'b0, 6'd3));
    send_request(number_req(32'hFFFFFFFF, RADIX_DEC, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0));
    send_request(number_req(32'hDEADBEEF, RADIX_HEX, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0));
    send_request(number_req(32'hDEADBEEF, RADIX_HEX, 1'b0, 1'b1, 1'b0, 1'b1, 6'd12));
    send_request(number_req(32'h80000000, RADIX_DEC, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0));
    send_request(number_req(32'hFFFFFFFB, RADIX_DEC, 1'b1, 1'b1, 1'b0, 1'b0, 6'd5));
    send_request(number_req(32'hFFFFFFFB, RADIX_HEX, 1'b1, 1'b0, 1'b0, 1'b1, 6'd0));
    send_request(number_req(32'hFFFFFFFB, RADIX_OCT, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0));
    send_request(number_req(32'd42, RADIX_DEC, 1'b0, 1'b1, 1'b1, 1'b0, 6'd8));
    send_request(number_req(32'd7, RADIX_DEC, 1'b0, 1'b0, 1'b1, 1'b0, 6'd63));
    send_request(number_req(32'h7FFFFFFF, RADIX_DEC, 1'b1, 1'b1, 1'b0, 1'b0, 6'd63));
    send_request(number_req(32'd123, RADIX_DEC, 1'b1, 1'b0, 1'b1, 1'b0, 6'd10));
    drain_output();
  endtask

  task automatic test_random_mix();
    fmt_request_t r;
    for (int phase = 0; phase < 4; phase++) begin
      quiet = (phase == 2);
      write_crlf((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
      for (int n = 0; n < 68; n++) begin
        r.action = 1'($urandom_range(0, 1));
        r.ch = ($urandom_range(0, 3) == 0) ? CHAR_LF : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
          0: r.value = $urandom_range(0, 20);
          1: r.value = 32'hFFFFFFFF - $urandom_range(0, 20);
          2: r.value = 32'h80000000 + $urandom_range(0, 20);
          default: r.value = $urandom;
        endcase
        r.radix = 2'($urandom_range(0, 3));
        r.sgn = 1'($urandom_range(0, 1));
        r.zpad = 1'($urandom_range(0, 1));
        r.left = 1'($urandom_range(0, 1));
        r.upper = 1'($urandom_range(0, 1));
        r.width = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 20));
        send_request(r);
      end
      drain_output();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_literals();
    test_crlf_off();
    test_number_formats();
    test_random_mix();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
